>>> hw/rtl/mkc_pkg.sv
package mkc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 6;
    localparam int COLS_CFG_W = 8;

    localparam logic [ROWS_CFG_W-1:0] ROWS_CFG_RESET = 6'd32;
    localparam logic [COLS_CFG_W-1:0] COLS_CFG_RESET = 8'd128;

    // Smallest grid edge that the carver works with.
    localparam int MIN_DIM = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CARVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic       carved;
        logic [1:0] carved_dir;
        logic [4:0] wall_row;
        logic [6:0] wall_col;
        logic       pos_open;
    } mkc_result_t;

endpackage

>>> hw/rtl/maze_kruskal_union_carver_top.sv
// Grid maze carver built on labeled disjoint sets, one command per beat and one result beat
// per command. Set labels live in a label RAM of ceil(MAX_ROWS/2)*ceil(MAX_COLS/2) entries
// and the open bits in a position RAM of MAX_ROWS*MAX_COLS entries, both with registered
// reads. A carve that opens a wall reads the cell's label, then takes the directions in
// order, skipping each that falls off the grid and reading and comparing the label of each
// other neighbor; it then makes three position writes, runs a relabel scan that streams
// every label slot through the label RAM port once, drains the scan and loads the result.
// A clear sweeps both RAMs one entry per cycle; the same sweep runs after reset, with
// s_ready low, before the first command is taken. The input is ready again from the same
// edge that loads a result. A finished result waits in the output register while the next
// command is accepted and worked on; that command then holds in its last cycle until the
// output register is free. Configuration writes are taken at any time but must only be
// made while the block is idle.
module maze_kruskal_union_carver_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mkc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mkc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [4:0]                        s_pos_row,
    input  logic [6:0]                        s_pos_col,
    input  logic [7:0]                        s_dir_order,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_carved,
    output logic [1:0]                        m_carved_dir,
    output logic [4:0]                        m_wall_row,
    output logic [6:0]                        m_wall_col,
    output logic                              m_pos_open
);

    localparam int LBL_DEPTH = ((MAX_ROWS + 1) / 2) * ((MAX_COLS + 1) / 2);
    localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int LA_W      = $clog2(LBL_DEPTH);
    localparam int MA_W      = $clog2(MAP_DEPTH);

    logic [mkc_pkg::ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [mkc_pkg::COLS_CFG_W-1:0] cols_cfg_reg;

    mkc_pkg::mkc_result_t result;

    logic            lbl_we;
    logic [LA_W-1:0] lbl_waddr, lbl_wdata, lbl_raddr, lbl_rdata;
    logic            map_we, map_wdata, map_rdata;
    logic [MA_W-1:0] map_waddr, map_raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= mkc_pkg::ROWS_CFG_RESET;
            cols_cfg_reg <= mkc_pkg::COLS_CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mkc_pkg::REG_ROWS: rows_cfg_reg <= cfg_wdata[mkc_pkg::ROWS_CFG_W-1:0];
                mkc_pkg::REG_COLS: cols_cfg_reg <= cfg_wdata[mkc_pkg::COLS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mkc_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .LBL_DEPTH (LBL_DEPTH),
        .MAP_DEPTH (MAP_DEPTH),
        .LA_W      (LA_W),
        .MA_W      (MA_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rows_cfg    (rows_cfg_reg),
        .cols_cfg    (cols_cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pos_row   (s_pos_row),
        .s_pos_col   (s_pos_col),
        .s_dir_order (s_dir_order),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (result),
        .lbl_we      (lbl_we),
        .lbl_waddr   (lbl_waddr),
        .lbl_wdata   (lbl_wdata),
        .lbl_raddr   (lbl_raddr),
        .lbl_rdata   (lbl_rdata),
        .map_we      (map_we),
        .map_waddr   (map_waddr),
        .map_wdata   (map_wdata),
        .map_raddr   (map_raddr),
        .map_rdata   (map_rdata)
    );

    mkc_ram #(
        .DEPTH (LBL_DEPTH),
        .WIDTH (LA_W),
        .AW    (LA_W)
    ) u_label_ram (
        .aclk  (aclk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    mkc_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (1),
        .AW    (MA_W)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign m_carved     = result.carved;
    assign m_carved_dir = result.carved_dir;
    assign m_wall_row   = result.wall_row;
    assign m_wall_col   = result.wall_col;
    assign m_pos_open   = result.pos_open;

    // Only one command is in flight, so an accepted beat closes the input at once.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a command was still in work");

    // Position RAM is written only while a command or the reset sweep is running.
    a_map_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        map_we |-> !s_ready)
        else $error("position RAM written while idle");

    a_no_carve_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_carved |-> m_carved_dir == 2'd0 && m_wall_row == 5'd0 &&
                                 m_wall_col == 7'd0)
        else $error("wall fields set without a carve");

    // A wall sits between two cells, so exactly one of its coordinates is even.
    a_wall_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_carved |-> (m_wall_row[0] ^ m_wall_col[0]) && !m_pos_open)
        else $error("opened wall position is not between two cells");

endmodule

>>> hw/rtl/mkc_ram.sv
module mkc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mkc_ctrl.sv
module mkc_ctrl #(
    parameter int MAX_ROWS  = 32,
    parameter int MAX_COLS  = 128,
    parameter int LBL_DEPTH = ((MAX_ROWS + 1) / 2) * ((MAX_COLS + 1) / 2),
    parameter int MAP_DEPTH = MAX_ROWS * MAX_COLS,
    parameter int LA_W      = $clog2(LBL_DEPTH),
    parameter int MA_W      = $clog2(MAP_DEPTH)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mkc_pkg::ROWS_CFG_W-1:0]    rows_cfg,
    input  logic [mkc_pkg::COLS_CFG_W-1:0]    cols_cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [4:0]                        s_pos_row,
    input  logic [6:0]                        s_pos_col,
    input  logic [7:0]                        s_dir_order,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mkc_pkg::mkc_result_t              m_result,
    output logic                              lbl_we,
    output logic [LA_W-1:0]                   lbl_waddr,
    output logic [LA_W-1:0]                   lbl_wdata,
    output logic [LA_W-1:0]                   lbl_raddr,
    input  logic [LA_W-1:0]                   lbl_rdata,
    output logic                              map_we,
    output logic [MA_W-1:0]                   map_waddr,
    output logic                              map_wdata,
    output logic [MA_W-1:0]                   map_raddr,
    input  logic                              map_rdata
);

    localparam int LBL_COLS = (MAX_COLS + 1) / 2;
    localparam int RW = (($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5) + 2;
    localparam int CW = (($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7) + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SWEEP, ST_CUR_RD, ST_CUR_LAT, ST_TRY, ST_NB_CMP,
        ST_OPEN_CELL, ST_OPEN_WALL, ST_OPEN_NB, ST_SCAN, ST_SCAN_END,
        ST_MAP_RD, ST_MAP_LAT, ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [7:0]            order_reg, order_next;
    logic [1:0]            k_reg, k_next;
    logic [LA_W-1:0]       lc_reg, lc_next;
    logic [LA_W-1:0]       ln_reg, ln_next;
    logic [MA_W-1:0]       cnt_reg, cnt_next;
    logic [LA_W-1:0]       scan_reg, scan_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [LA_W-1:0]       pend_addr_reg, pend_addr_next;
    logic                  clr_res_reg, clr_res_next;
    logic                  m_valid_reg, m_valid_next;
    mkc_pkg::mkc_result_t  res_reg, res_next;
    mkc_pkg::mkc_result_t  out_reg, out_next;

    logic [RW-1:0] rows_ext, rows_eff;
    logic [CW-1:0] cols_ext, cols_eff;
    logic          cell_ok, read_in_grid, nb_ok;
    logic [1:0]    dir_sel;
    logic [RW-1:0] nb_r, wall_r;
    logic [CW-1:0] nb_c, wall_c;

    function automatic logic [LA_W-1:0] slot_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        slot_of = LA_W'((r >> 1) * LBL_COLS + (c >> 1));
    endfunction

    function automatic logic [MA_W-1:0] pos_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        pos_of = MA_W'(r * MAX_COLS + c);
    endfunction

    // Register values outside the usable range are clamped.
    assign rows_ext = RW'(rows_cfg);
    assign cols_ext = CW'(cols_cfg);

    always_comb begin
        if (rows_ext < RW'(mkc_pkg::MIN_DIM)) begin
            rows_eff = RW'(mkc_pkg::MIN_DIM);
        end else if (rows_ext > RW'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        if (cols_ext < CW'(mkc_pkg::MIN_DIM)) begin
            cols_eff = CW'(mkc_pkg::MIN_DIM);
        end else if (cols_ext > CW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    assign cell_ok = row_reg[0] && col_reg[0] && (row_reg < rows_eff) &&
                     ((col_reg + CW'(3)) <= cols_eff);
    assign read_in_grid = (row_reg < rows_eff) && (col_reg < cols_eff);

    assign dir_sel = order_reg[{k_reg, 1'b0} +: 2];

    always_comb begin
        nb_r   = row_reg;
        nb_c   = col_reg;
        wall_r = row_reg;
        wall_c = col_reg;
        nb_ok  = 1'b0;
        case (dir_sel)
            mkc_pkg::DIR_UP: begin
                nb_ok  = row_reg >= RW'(2);
                nb_r   = row_reg - RW'(2);
                wall_r = row_reg - RW'(1);
            end
            mkc_pkg::DIR_RIGHT: begin
                nb_ok  = (col_reg + CW'(5)) <= cols_eff;
                nb_c   = col_reg + CW'(2);
                wall_c = col_reg + CW'(1);
            end
            mkc_pkg::DIR_DOWN: begin
                nb_ok  = (row_reg + RW'(2)) < rows_eff;
                nb_r   = row_reg + RW'(2);
                wall_r = row_reg + RW'(1);
            end
            mkc_pkg::DIR_LEFT: begin
                nb_ok  = col_reg >= CW'(2);
                nb_c   = col_reg - CW'(2);
                wall_c = col_reg - CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        order_next      = order_reg;
        k_next          = k_reg;
        lc_next         = lc_reg;
        ln_next         = ln_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        clr_res_next    = clr_res_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;

        lbl_we    = 1'b0;
        lbl_waddr = pend_addr_reg;
        lbl_wdata = lc_reg;
        lbl_raddr = '0;
        map_we    = 1'b0;
        map_waddr = pos_of(row_reg, col_reg);
        map_wdata = 1'b1;
        map_raddr = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // The label requested during the relabel scan lands now from the label RAM's read register.
        if (pend_valid_reg && (lbl_rdata == ln_reg)) begin
            lbl_we = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    row_next   = RW'(s_pos_row);
                    col_next   = CW'(s_pos_col);
                    order_next = s_dir_order;
                    res_next   = '0;
                    case (s_cmd)
                        mkc_pkg::CMD_CLEAR: begin
                            clr_res_next = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_SWEEP;
                        end
                        mkc_pkg::CMD_CARVE: state_next = ST_CUR_RD;
                        mkc_pkg::CMD_READ:  state_next = ST_MAP_RD;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (cnt_reg < MA_W'(LBL_DEPTH)) begin
                    lbl_we    = 1'b1;
                    lbl_waddr = cnt_reg[LA_W-1:0];
                    lbl_wdata = cnt_reg[LA_W-1:0];
                end
                map_we    = 1'b1;
                map_waddr = cnt_reg;
                map_wdata = 1'b0;
                cnt_next  = cnt_reg + MA_W'(1);
                if (cnt_reg == MA_W'(MAP_DEPTH - 1)) begin
                    clr_res_next = 1'b0;
                    state_next   = clr_res_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_CUR_RD: begin
                if (cell_ok) begin
                    lbl_raddr  = slot_of(row_reg, col_reg);
                    state_next = ST_CUR_LAT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CUR_LAT: begin
                lc_next    = lbl_rdata;
                k_next     = 2'd0;
                state_next = ST_TRY;
            end
            ST_TRY: begin
                if (nb_ok) begin
                    lbl_raddr  = slot_of(nb_r, nb_c);
                    state_next = ST_NB_CMP;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_DONE;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_NB_CMP: begin
                if (lbl_rdata == lc_reg) begin
                    if (k_reg == 2'd3) begin
                        state_next = ST_DONE;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_TRY;
                    end
                end else begin
                    ln_next             = lbl_rdata;
                    res_next.carved     = 1'b1;
                    res_next.carved_dir = dir_sel;
                    res_next.wall_row   = wall_r[4:0];
                    res_next.wall_col   = wall_c[6:0];
                    state_next          = ST_OPEN_CELL;
                end
            end
            ST_OPEN_CELL: begin
                map_we     = 1'b1;
                state_next = ST_OPEN_WALL;
            end
            ST_OPEN_WALL: begin
                map_we     = 1'b1;
                map_waddr  = pos_of(wall_r, wall_c);
                state_next = ST_OPEN_NB;
            end
            ST_OPEN_NB: begin
                map_we          = 1'b1;
                map_waddr       = pos_of(nb_r, nb_c);
                scan_next       = '0;
                pend_valid_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                // Read slot i while slot i-1 is written back; never the same entry.
                lbl_raddr       = scan_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = scan_reg;
                if (scan_reg == LA_W'(LBL_DEPTH - 1)) begin
                    state_next = ST_SCAN_END;
                end else begin
                    scan_next = scan_reg + LA_W'(1);
                end
            end
            ST_SCAN_END: begin
                pend_valid_next = 1'b0;
                state_next      = ST_DONE;
            end
            ST_MAP_RD: begin
                if (read_in_grid) begin
                    map_raddr  = pos_of(row_reg, col_reg);
                    state_next = ST_MAP_LAT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MAP_LAT: begin
                res_next.pos_open = map_rdata;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        order_reg     <= order_next;
        k_reg         <= k_next;
        lc_reg        <= lc_next;
        ln_reg        <= ln_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            cnt_reg        <= '0;
            clr_res_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_res_reg    <= clr_res_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule
